[sv/sssp_pkg.sv]
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants of the shortest path engine
// Field widths, request and status codes, and the stored edge layout.
// ----------------------------------------------------------------------------
package sssp_pkg;

   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 256;
   localparam int WeightBits  = 16;

   localparam int VertexBits  = $clog2(MaxVertices);
   localparam int EdgeBits    = $clog2(MaxEdges);
   localparam int CountBits   = $clog2(MaxEdges + 1);
   localparam int DistBits    = 22;
   localparam int CfgBits     = 7;

   localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};
   localparam logic [CfgBits-1:0] CfgReset = CfgBits'(MaxVertices);

   localparam logic [1:0] ReqAdd   = 2'd0;
   localparam logic [1:0] ReqRun   = 2'd1;
   localparam logic [1:0] ReqClear = 2'd2;
   localparam logic [1:0] ReqNone  = 2'd3;

   localparam logic [1:0] StatOk    = 2'd0;
   localparam logic [1:0] StatFull  = 2'd1;
   localparam logic [1:0] StatRange = 2'd2;

   localparam logic [2:0] CsrAddrVertices = 3'd0;

   typedef struct packed {
      logic [5:0]            end_a;
      logic [5:0]            end_b;
      logic [WeightBits-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  end_a;
      logic [5:0]  end_b;
      logic [15:0] weight;
      logic [5:0]  source_vertex;
   } req_type;

   typedef struct packed {
      logic [5:0]          vertex;
      logic [DistBits-1:0] distance;
      logic                unreachable;
      logic                last;
      logic [1:0]          status;
   } rsp_type;

endpackage

[sv/sssp_if.sv]
// ----------------------------------------------------------------------------
// sssp_req_if / sssp_rsp_if: valid/ready channels of the engine
// Each carries one item of the request or result payload.
// ----------------------------------------------------------------------------
interface sssp_req_if;
   logic               valid;
   logic               ready;
   sssp_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sssp_rsp_if;
   logic               valid;
   logic               ready;
   sssp_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/sssp_edge_ram.sv]
// ----------------------------------------------------------------------------
// sssp_edge_ram: edge store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module sssp_edge_ram (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [sssp_pkg::EdgeBits-1:0]      wr_addr,
   input  sssp_pkg::edge_type                 wr_data,
   input  logic [sssp_pkg::EdgeBits-1:0]      rd_addr,
   output sssp_pkg::edge_type                 rd_data
);

   sssp_pkg::edge_type mem [sssp_pkg::MaxEdges];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/single_source_shortest_paths.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_paths: Dijkstra engine by linear minimum scan
// Stores an undirected edge list and answers run requests with one
// distance item per vertex.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake       Content
// req_*     in         valid/ready     add edge, run from source, clear
// rsp_*     out        valid/ready     vertex distance or status
// csr_*     in         APB, pready=1   vertices_in_use at address 0
//
// Add, clear and refused items are accepted in S_IDLE and answered by one
// status item from S_STATUS, which holds until rsp ready is high.
// A run takes a setup state, then up to n passes for n vertices and E
// stored edges. Each pass scans the vertices through the registered
// distance read, walks the edge store with an address and a data state per
// edge (and a compare state when the edge touches the picked vertex) plus
// one address state to see the end, and marks the pick. A last scan finds
// nothing, and each of the n result items goes out through an address and
// an emit state, holding in the emit state until ready is high.
// Reset is synchronous; it clears the edge count, the state and the reached,
// done and scan flags and sets the vertex count register to 64. The edge and
// distance stores are not cleared.
// A stalled result holds the sequencer; no item is accepted until every
// result of the current item has been taken.
// ----------------------------------------------------------------------------
module single_source_shortest_paths (
   input  logic                clock,
   input  logic                reset,
   sssp_req_if.sink            req,
   sssp_rsp_if.source          rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int VB = sssp_pkg::VertexBits;
   localparam int DB = sssp_pkg::DistBits;
   localparam int EB = sssp_pkg::EdgeBits;
   localparam int CB = sssp_pkg::CountBits;
   localparam int MaxV = sssp_pkg::MaxVertices;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_SCAN, S_EDGE_ADDR, S_EDGE_DATA, S_EDGE_CMP, S_MARK,
      S_EMIT_ADDR, S_EMIT, S_STATUS
   } state_type;

   state_type             state_ff, state_in;
   logic [sssp_pkg::CfgBits-1:0] nv_cfg_ff;
   logic [CB-1:0]         held_ff, held_in;
   logic [VB:0]           n_ff, n_in;          // active vertex count, latched per item
   logic [VB:0]           vi_ff, vi_in;        // vertex scan index
   logic [CB-1:0]         ei_ff, ei_in;        // edge scan index
   logic                  found_ff, found_in;
   logic [VB-1:0]         pick_ff, pick_in;
   logic [DB-1:0]         pdist_ff, pdist_in;  // distance of current pick
   logic                  sv_ff, sv_in;        // scan read data valid
   logic [VB-1:0]         sidx_ff, sidx_in;    // vertex of the scan read data
   logic [VB-1:0]         other_ff, other_in;  // far end of the edge being relaxed
   logic [DB-1:0]         nd_ff, nd_in;        // candidate distance for other_ff
   logic [1:0]            stat_ff, stat_in;
   logic [MaxV-1:0]       reached_ff, done_ff;
   logic [DB-1:0]         dist_mem [MaxV];
   logic [DB-1:0]         dist_rd_ff;

   // Scratch; all but rd_edge, the registered edge store output, are driven combinationally.
   sssp_pkg::edge_type    rd_edge, wr_edge;
   logic                  wr_en;
   logic [EB-1:0]         rd_addr;
   logic [VB:0]           nact;
   logic [VB-1:0]         other, vcur;
   logic                  hit;
   logic [DB:0]           sum;
   logic [DB-1:0]         nd;
   logic                  take;
   logic                  improve;
   logic                  run_start;
   logic                  dist_we;
   logic [VB-1:0]         dist_raddr, dist_waddr;
   logic [DB-1:0]         dist_wdata;
   logic                  accept;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == sssp_pkg::CsrAddrVertices) ?
                       {25'd0, nv_cfg_ff} : 32'd0;

   always_comb begin
      if (nv_cfg_ff == '0) begin
         nact = (VB+1)'(1);
      end else if (nv_cfg_ff > sssp_pkg::CfgBits'(MaxV)) begin
         nact = (VB+1)'(MaxV);
      end else begin
         nact = (VB+1)'(nv_cfg_ff);
      end
   end

   assign accept  = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign wr_edge = '{end_a: req.payload.end_a, end_b: req.payload.end_b,
                      weight: req.payload.weight[sssp_pkg::WeightBits-1:0]};
   assign rd_addr = ei_ff[EB-1:0];
   assign run_start = accept && req.payload.req_type == sssp_pkg::ReqRun &&
                      (VB+1)'(req.payload.source_vertex) < nact;

   sssp_edge_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_ff[EB-1:0]),
      .wr_data (wr_edge),
      .rd_addr (rd_addr),
      .rd_data (rd_edge)
   );

   assign vcur = vi_ff[VB-1:0];

   // Shared relax unit. The edge read lands in S_EDGE_DATA, where the far end
   // is looked up; the compare against its stored distance follows in
   // S_EDGE_CMP once the registered distance read returns.
   always_comb begin
      hit = 1'b0;
      other = rd_edge.end_b;
      if ((VB+1)'(rd_edge.end_a) < n_ff && (VB+1)'(rd_edge.end_b) < n_ff) begin
         if (rd_edge.end_a == pick_ff) begin
            hit = 1'b1;
            other = rd_edge.end_b;
         end else if (rd_edge.end_b == pick_ff) begin
            hit = 1'b1;
            other = rd_edge.end_a;
         end
      end
      sum = {1'b0, pdist_ff} + (DB+1)'(rd_edge.weight);
      nd  = sum[DB] ? sssp_pkg::DistMax : sum[DB-1:0];
      improve = (state_ff == S_EDGE_CMP) &&
                (!reached_ff[other_ff] || dist_rd_ff > nd_ff);
      // The scan compares the vertex read in the previous cycle.
      take = sv_ff && !done_ff[sidx_ff] && reached_ff[sidx_ff] &&
             (!found_ff || dist_rd_ff < pdist_ff);
   end

   // Distance store: one write port and one registered read port. A run
   // start writes the source to zero; an improving relax writes the far end.
   always_comb begin
      dist_raddr = (state_ff == S_EDGE_DATA) ? other : vcur;
      dist_we    = run_start || improve;
      dist_waddr = run_start ? req.payload.source_vertex : other_ff;
      dist_wdata = run_start ? '0 : nd_ff;
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      dist_rd_ff <= dist_mem[dist_raddr];
   end

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      n_in     = n_ff;
      vi_in    = vi_ff;
      ei_in    = ei_ff;
      found_in = found_ff;
      pick_in  = pick_ff;
      pdist_in = pdist_ff;
      sv_in    = 1'b0;
      sidx_in  = sidx_ff;
      other_in = other_ff;
      nd_in    = nd_ff;
      stat_in  = stat_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in = nact;
               unique case (req.payload.req_type)
                  sssp_pkg::ReqAdd: begin
                     state_in = S_STATUS;
                     if ((VB+1)'(req.payload.end_a) >= nact ||
                         (VB+1)'(req.payload.end_b) >= nact) begin
                        stat_in = sssp_pkg::StatRange;
                     end else if (held_ff >= CB'(sssp_pkg::MaxEdges)) begin
                        stat_in = sssp_pkg::StatFull;
                     end else begin
                        stat_in = sssp_pkg::StatOk;
                        wr_en   = 1'b1;
                        held_in = held_ff + CB'(1);
                     end
                  end
                  sssp_pkg::ReqRun: begin
                     if ((VB+1)'(req.payload.source_vertex) >= nact) begin
                        stat_in  = sssp_pkg::StatRange;
                        state_in = S_STATUS;
                     end else begin
                        state_in = S_INIT;
                     end
                  end
                  sssp_pkg::ReqClear: begin
                     held_in  = '0;
                     stat_in  = sssp_pkg::StatOk;
                     state_in = S_STATUS;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            vi_in    = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (take) begin
               found_in = 1'b1;
               pick_in  = sidx_ff;
               pdist_in = dist_rd_ff;
            end
            if (vi_ff == n_ff) begin
               // The read of the last vertex is compared in this cycle.
               if (found_ff || take) begin
                  ei_in    = '0;
                  state_in = S_EDGE_ADDR;
               end else begin
                  vi_in    = '0;
                  state_in = S_EMIT_ADDR;
               end
            end else begin
               sv_in   = 1'b1;
               sidx_in = vcur;
               vi_in   = vi_ff + (VB+1)'(1);
            end
         end
         S_EDGE_ADDR: begin
            // Address ei_ff presented; data arrives next cycle.
            if (ei_ff == held_ff) begin
               state_in = S_MARK;
            end else begin
               state_in = S_EDGE_DATA;
            end
         end
         S_EDGE_DATA: begin
            if (hit) begin
               other_in = other;
               nd_in    = nd;
               state_in = S_EDGE_CMP;
            end else begin
               ei_in    = ei_ff + CB'(1);
               state_in = S_EDGE_ADDR;
            end
         end
         S_EDGE_CMP: begin
            ei_in    = ei_ff + CB'(1);
            state_in = S_EDGE_ADDR;
         end
         S_MARK: begin
            vi_in    = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         S_EMIT_ADDR: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp.ready) begin
               if (vi_ff + (VB+1)'(1) == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  vi_in    = vi_ff + (VB+1)'(1);
                  state_in = S_EMIT_ADDR;
               end
            end
         end
         S_STATUS: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         nv_cfg_ff  <= sssp_pkg::CfgReset;
         held_ff    <= '0;
         reached_ff <= '0;
         done_ff    <= '0;
         sv_ff      <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         sv_ff    <= sv_in;
         found_ff <= found_in;
         if (csr_psel && csr_penable && csr_pwrite &&
             csr_paddr == sssp_pkg::CsrAddrVertices) begin
            nv_cfg_ff <= csr_pwdata[sssp_pkg::CfgBits-1:0];
         end
         if (run_start) begin
            reached_ff <= MaxV'(1) << req.payload.source_vertex;
            done_ff    <= '0;
         end else begin
            if (improve) begin
               reached_ff[other_ff] <= 1'b1;
            end
            if (state_ff == S_MARK) begin
               done_ff[pick_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      vi_ff    <= vi_in;
      ei_ff    <= ei_in;
      pick_ff  <= pick_in;
      pdist_ff <= pdist_in;
      sidx_ff  <= sidx_in;
      other_ff <= other_in;
      nd_ff    <= nd_in;
      stat_ff  <= stat_in;
   end

   always_comb begin
      rsp.valid = (state_ff == S_EMIT) || (state_ff == S_STATUS);
      rsp.payload = '0;
      if (state_ff == S_EMIT) begin
         rsp.payload.vertex      = vcur;
         rsp.payload.distance    = reached_ff[vcur] ? dist_rd_ff : '0;
         rsp.payload.unreachable = !reached_ff[vcur];
         rsp.payload.last        = (vi_ff + (VB+1)'(1) == n_ff);
         rsp.payload.status      = sssp_pkg::StatOk;
      end else begin
         rsp.payload.last   = 1'b1;
         rsp.payload.status = stat_ff;
      end
   end

   // Edge reads are only ever issued below the edge count.
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EDGE_DATA || state_ff == S_EDGE_CMP) |-> ei_ff < held_ff)
      else $error("edge read past the edge count");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready while result pending");
   a_held: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CB'(sssp_pkg::MaxEdges)) else $error("edge count overflow");
   a_pick: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> reached_ff[pick_ff] && !done_ff[pick_ff])
      else $error("bad pick");

endmodule
